// File: hw/rtl/pcdp_pkg.sv
package pcdp_pkg;

  localparam int FS_W      = 14;
  localparam int WARMUP_W  = 32;
  localparam int TIMEOUT_W = 21;
  localparam int MAXPPM_W  = 16;
  localparam int PPM_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // Fixed sensor offsets: 2 ms of high time, 4 ms of period.
  localparam int HIGH_OFFSET   = 2000;
  localparam int PERIOD_OFFSET = 4000;

  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PPM    = 3'd3;

  localparam logic [FS_W-1:0]      RST_FULL_SCALE = 14'd2000;
  localparam logic [WARMUP_W-1:0]  RST_WARMUP     = 32'd180000000;
  localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT    = 21'd1506000;
  localparam logic [MAXPPM_W-1:0]  RST_MAX_PPM    = 16'd2000;

  localparam logic       OP_TICK  = 1'b0;
  localparam logic       OP_START = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_WARMUP  = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  typedef struct packed {
    logic op;
    logic pin_level;
  } in_item_t;

  typedef struct packed {
    logic [PPM_W-1:0] ppm;
    logic [1:0]       status;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       tick;        // advance uptime, capture pin level
    logic       clr_counts;
    logic       wait_bump;
    logic       high_set1;
    logic       high_bump;
    logic       low_set1;
    logic       low_bump;
    logic       div_start;
    logic       div_step;
    logic       emit;        // load output with zero ppm and emit_status
    logic [1:0] emit_status;
    logic       emit_div;    // load output from the quotient
  } pcdp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic warm;
    logic last_level;
    logic wait_exp;
    logic high_exp;
    logic low_exp;
    logic low1_exp;
    logic div_needed;    // denominator and numerator both positive
    logic div_last;
    logic out_valid;
  } pcdp_status_t;

endpackage

// File: hw/rtl/pcdp_ctrl.sv
module pcdp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  pcdp_pkg::in_item_t     in_data,
  input  logic                   out_stall,
  output logic                   in_stall,
  input  pcdp_pkg::pcdp_status_t stat,
  output pcdp_pkg::pcdp_cmd_t    cmd
);
  import pcdp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ALIGN = 6'b000010,
    S_HIGH  = 6'b000100,
    S_LOW   = 6'b001000,
    S_DIV   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   out_blocked;
  logic   accept;
  logic   lvl;

  assign out_blocked = stat.out_valid && out_stall;
  assign in_stall    = (state == S_DIV) || (state == S_FIN) || out_blocked;
  assign accept      = in_valid && !in_stall;
  assign lvl         = in_data.pin_level;

  always_comb begin
    state_next = state;
    cmd        = '0;
    if (accept && in_data.op == OP_START) begin
      if (stat.warm) begin
        cmd.emit        = 1'b1;
        cmd.emit_status = ST_WARMUP;
        state_next      = S_IDLE;
      end else begin
        cmd.clr_counts = 1'b1;
        state_next     = S_ALIGN;
      end
    end else if (accept) begin
      cmd.tick = 1'b1;
      case (state)
        S_ALIGN: begin
          if (!stat.last_level && lvl) begin
            cmd.high_set1 = 1'b1;
            state_next    = S_HIGH;
          end else begin
            cmd.wait_bump = 1'b1;
            if (stat.wait_exp) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_TIMEOUT;
              state_next      = S_IDLE;
            end
          end
        end
        S_HIGH: begin
          if (lvl) begin
            cmd.high_bump = 1'b1;
            if (stat.high_exp) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_TIMEOUT;
              state_next      = S_IDLE;
            end
          end else begin
            cmd.low_set1 = 1'b1;
            if (stat.low1_exp) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_TIMEOUT;
              state_next      = S_IDLE;
            end else begin
              state_next = S_LOW;
            end
          end
        end
        S_LOW: begin
          if (!lvl) begin
            cmd.low_bump = 1'b1;
            if (stat.low_exp) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_TIMEOUT;
              state_next      = S_IDLE;
            end
          end else if (stat.div_needed) begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end else begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_RANGE;
            state_next      = S_IDLE;
          end
        end
        default: ;
      endcase
    end else begin
      case (state)
        S_DIV: begin
          cmd.div_step = 1'b1;
          if (stat.div_last) begin
            state_next = S_FIN;
          end
        end
        S_FIN: begin
          if (!out_blocked) begin
            cmd.emit_div = 1'b1;
            state_next   = S_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hw/rtl/pcdp_datapath.sv
module pcdp_datapath #(
  parameter int COUNT_BITS = 21
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pcdp_pkg::in_item_t                  in_data,
  input  logic                                cfg_valid,
  input  logic [pcdp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcdp_pkg::CFG_DAT_W-1:0]      cfg_data,
  input  logic                                out_stall,
  output logic                                out_valid,
  output pcdp_pkg::out_item_t                 out_data,
  input  pcdp_pkg::pcdp_cmd_t                 cmd,
  output pcdp_pkg::pcdp_status_t              stat
);
  import pcdp_pkg::*;

  localparam int CB  = COUNT_BITS;
  localparam int NW  = FS_W + CB;         // numerator / quotient width
  localparam int DW  = CB + 1;            // positive denominator width
  localparam int CW  = $clog2(NW);
  localparam int EW  = 33;                // common width for timeout compares
  localparam logic [CB-1:0] CMAX = {CB{1'b1}};

  // configuration
  logic [FS_W-1:0]      full_scale;
  logic [WARMUP_W-1:0]  warmup;
  logic [TIMEOUT_W-1:0] timeout;
  logic [MAXPPM_W-1:0]  max_ppm;

  // measurement state
  logic                last_level;
  logic [CB-1:0]       high_count, low_count, wait_count;
  logic [WARMUP_W-1:0] uptime;

  // divider
  logic [NW-1:0] num, quo;
  logic [DW-1:0] den;
  logic [DW-1:0] rem;
  logic [CW-1:0] cnt;

  logic [CB-1:0] wait_inc, high_inc, low_inc;
  logic [CB+1:0] den_full;
  logic [CB-1:0] th_off;
  logic [NW-1:0] num_start;
  logic [DW:0]   rem_sh;
  logic          sub_ok;
  logic          q_ok;

  function automatic logic [CB-1:0] bump(input logic [CB-1:0] c);
    bump = (c < CMAX) ? c + 1'b1 : c;
  endfunction

  function automatic logic expired(input logic [CB-1:0] c, input logic [TIMEOUT_W-1:0] t);
    expired = (EW'(c) > EW'(t)) || (c == CMAX);
  endfunction

  assign wait_inc = bump(wait_count);
  assign high_inc = bump(high_count);
  assign low_inc  = bump(low_count);

  assign den_full  = (CB+2)'(high_count) + (CB+2)'(low_count) - (CB+2)'(PERIOD_OFFSET);
  assign th_off    = high_count - CB'(HIGH_OFFSET);
  assign num_start = {{CB{1'b0}}, full_scale} * {{FS_W{1'b0}}, th_off};

  assign rem_sh = {rem, num[NW-1]};
  assign sub_ok = rem_sh >= {1'b0, den};
  assign q_ok   = (quo != '0) && (quo <= NW'(max_ppm));

  assign stat.warm       = uptime < warmup;
  assign stat.last_level = last_level;
  assign stat.wait_exp   = expired(wait_inc, timeout);
  assign stat.high_exp   = expired(high_inc, timeout);
  assign stat.low_exp    = expired(low_inc, timeout);
  assign stat.low1_exp   = expired(CB'(1), timeout);
  assign stat.div_needed = !den_full[CB+1] && (den_full != '0) &&
                           (high_count > CB'(HIGH_OFFSET)) && (full_scale != '0);
  assign stat.div_last   = cnt == CW'(NW-1);
  assign stat.out_valid  = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= RST_FULL_SCALE;
      warmup     <= RST_WARMUP;
      timeout    <= RST_TIMEOUT;
      max_ppm    <= RST_MAX_PPM;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FULL_SCALE: full_scale <= cfg_data[FS_W-1:0];
        REG_WARMUP:     warmup     <= cfg_data[WARMUP_W-1:0];
        REG_TIMEOUT:    timeout    <= cfg_data[TIMEOUT_W-1:0];
        REG_MAX_PPM:    max_ppm    <= cfg_data[MAXPPM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level <= 1'b0;
      uptime     <= '0;
      high_count <= '0;
      low_count  <= '0;
      wait_count <= '0;
    end else begin
      if (cmd.tick) begin
        last_level <= in_data.pin_level;
        if (uptime != '1) begin
          uptime <= uptime + 1'b1;
        end
      end
      if (cmd.clr_counts) begin
        high_count <= '0;
        low_count  <= '0;
        wait_count <= '0;
      end
      if (cmd.wait_bump) wait_count <= wait_inc;
      if (cmd.high_set1) high_count <= CB'(1);
      if (cmd.high_bump) high_count <= high_inc;
      if (cmd.low_set1)  low_count  <= CB'(1);
      if (cmd.low_bump)  low_count  <= low_inc;
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      num <= num_start;
      den <= den_full[DW-1:0];
      rem <= '0;
      quo <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      num <= {num[NW-2:0], 1'b0};
      rem <= sub_ok ? DW'(rem_sh - {1'b0, den}) : rem_sh[DW-1:0];
      quo <= {quo[NW-2:0], sub_ok};
      cnt <= cnt + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_div) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.ppm    <= '0;
      out_data.status <= cmd.emit_status;
    end else if (cmd.emit_div) begin
      out_data.ppm    <= q_ok ? quo[PPM_W-1:0] : '0;
      out_data.status <= q_ok ? ST_OK : ST_RANGE;
    end
  end

endmodule

// File: hw/rtl/pwm_co2_duty_to_ppm.sv
// PWM duty-cycle CO2 decoder.
// Input channel (in_valid/in_stall/in_data): one transaction per microsecond
//   tick carrying the sampled pin level, or a start request (op = 1).
// Output channel (out_valid/out_stall/out_data): ppm and status, at most one
//   transaction per input transaction; a tick while idle gives none.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//   index 0 full scale, 1 warmup, 2 timeout, 3 max ppm; write while idle.
// Throughput: one transaction per cycle while measuring, unless a held result
//   stalls the output. The tick that ends a measurement starts a restoring
//   divider (one quotient bit per cycle); input stalls until the result is loaded.
// Results: warmup, timeout and no-positive-numerator or denominator answers are
//   in the output register the cycle after the transaction; a reading that needs
//   the divide (ok, zero or above max ppm) is there once the divider finishes.
// Reset (rst, synchronous): config registers return to default values, uptime and
//   counts clear, the output empties, the decoder goes idle.
// Output stall: a held result keeps in_stall high until it is taken.
module pwm_co2_duty_to_ppm #(
  parameter int COUNT_BITS = 21
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pcdp_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output pcdp_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pcdp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcdp_pkg::CFG_DAT_W-1:0] cfg_data
);
  import pcdp_pkg::*;

  pcdp_cmd_t    cmd;
  pcdp_status_t stat;

  // registers take writes in any cycle
  assign cfg_ready = 1'b1;

  // sequencing: phase tracking, request handling, divider control
  pcdp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // counters, config registers, divider, output register
  pcdp_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
